/* hdl/vpa_pkg.sv */
// ----------------------------------------------------------------------------
// vpa_pkg: shared types and codes of the variable partition allocator
// Holds result status codes, action codes, register indexes and fit codes.
// ----------------------------------------------------------------------------
package vpa_pkg;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NO_OWNER  = 2'd3;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [1:0] REG_FIT_METHOD  = 2'd0;
  localparam logic [1:0] REG_MEMORY_SIZE = 2'd1;
  localparam logic [1:0] REG_SPLIT_SLACK = 2'd2;

  localparam int ADDR_BITS     = 20;
  localparam int OWNER_BITS    = 16;
  localparam int CFG_DATA_BITS = 20;
  localparam int STATUS_BITS   = 2;
  localparam int COUNT_BITS    = 8;

endpackage

/* hdl/vpa_if.sv */
// ----------------------------------------------------------------------------
// vpa interfaces: valid/ready channels of the allocator
// Request, result and configuration write channels.
// ----------------------------------------------------------------------------
interface vpa_req_if
  import vpa_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [OWNER_BITS-1:0] owner;
  logic [ADDR_BITS-1:0]  request_size;
  modport source  (output valid, action, owner, request_size, input ready);
  modport sink    (input valid, action, owner, request_size, output ready);
  modport monitor (input valid, action, owner, request_size, ready);
endinterface

interface vpa_rsp_if
  import vpa_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [ADDR_BITS-1:0]   base_address;
  logic [ADDR_BITS-1:0]   granted_size;
  logic [ADDR_BITS-1:0]   free_remaining;
  logic [COUNT_BITS-1:0]  segment_count;
  modport source  (output valid, status, base_address, granted_size, free_remaining,
                   segment_count, input ready);
  modport sink    (input valid, status, base_address, granted_size, free_remaining,
                   segment_count, output ready);
  modport monitor (input valid, status, base_address, granted_size, free_remaining,
                   segment_count, ready);
endinterface

interface vpa_cfg_if
  import vpa_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [1:0]               index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source  (output valid, index, data, input ready);
  modport sink    (input valid, index, data, output ready);
  modport monitor (input valid, index, data, ready);
endinterface

/* hdl/variable_partition_allocator_top.sv */
// ----------------------------------------------------------------------------
// variable_partition_allocator_top: segment table allocator with coalescing
// First, best or worst fit over an ordered segment table kept in one memory.
// ----------------------------------------------------------------------------
// channel | dir | beat carries
// req     | in  | action, owner, request_size
// rsp     | out | status, base_address, granted_size, free_remaining, segment_count
// cfg     | in  | index, data (fit_method, memory_size, split_slack)
//
// One item at a time. The scan reads one entry per cycle, then a decide
// state follows. A splitting allocate moves every later entry up by one (a
// read state and a write state per moved entry); a release reads the
// neighbors that exist, merges free ones and moves later entries down the same way.
// The single-port table memory sets this pace.
// Reset: table is one free segment; no clearing pass (entries past the count
// are never used). rsp stalls hold the result register; req is then blocked.
// A cfg beat is taken only when idle, and an offered cfg beat holds off req.
// ----------------------------------------------------------------------------
module variable_partition_allocator_top
  import vpa_pkg::*;
#(
  parameter int SEGMENTS = 128
) (
  input logic clk,
  input logic rst,
  vpa_req_if.sink   req,
  vpa_rsp_if.source rsp,
  vpa_cfg_if.sink   cfg
);

  localparam int IB = $clog2(SEGMENTS);   // table index width
  localparam int CB = $clog2(SEGMENTS + 1); // count width

  typedef struct packed {
    logic [ADDR_BITS-1:0]  base;
    logic [ADDR_BITS-1:0]  length;
    logic                  free;
    logic [OWNER_BITS-1:0] owner;
  } seg_t;

  // state codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;  // issue reads, compare returned entries
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_UPRD   = 4'd3;  // shift up: read j-1
  localparam logic [3:0] S_UPWR   = 4'd4;  // shift up: write j
  localparam logic [3:0] S_FIN_A  = 4'd5;  // write granted part at k
  localparam logic [3:0] S_RD_NB  = 4'd6;  // release: read k+1
  localparam logic [3:0] S_RD_PV  = 4'd7;  // release: read k-1
  localparam logic [3:0] S_MERGE  = 4'd8;
  localparam logic [3:0] S_DNRD   = 4'd9;  // shift down: read j+drops
  localparam logic [3:0] S_DNWR   = 4'd10; // shift down: write j
  localparam logic [3:0] S_DONE   = 4'd11;

  // configuration
  logic [1:0]           fit_method;
  logic [ADDR_BITS-1:0] memory_size;
  logic [9:0]           split_slack;

  // table memory, one port, registered read
  seg_t    mem [SEGMENTS];
  seg_t    rd_data;
  logic          we;
  logic [IB-1:0] addr;
  seg_t          wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wr_data;
    end
    rd_data <= mem[addr];
  end

  logic [3:0]           state;
  logic [CB-1:0]        seg_total;
  logic [ADDR_BITS-1:0] free_units;
  logic                 act;
  logic [OWNER_BITS-1:0] own;
  logic [ADDR_BITS-1:0] rsize;
  logic [CB-1:0]        scan_i;    // next index to issue
  logic [CB-1:0]        cmp_i;     // index of rd_data
  logic                 cmp_v;
  logic                 found;
  logic [IB-1:0]        pick;
  seg_t                 pick_seg;
  logic [ADDR_BITS-1:0] best;
  logic [CB-1:0]        j;
  logic                 rem_a, rem_b; // merge with next / previous
  seg_t                 nb_seg, pv_seg;
  logic [1:0]           r_status;
  logic [ADDR_BITS-1:0] r_base, r_size;
  logic                 rsp_valid;
  logic [1:0]           drops;

  logic boot; // table entry 0 must be rewritten after reset or memory_size write

  // compare of one returned entry
  logic                 hit;
  logic [ADDR_BITS-1:0] slack;
  always_comb begin
    slack = rd_data.length - rsize;
    hit = 1'b0;
    if (cmp_v) begin
      if (act == ACT_ALLOC) begin
        if (rd_data.free && rd_data.length >= rsize) begin
          priority case (fit_method)
            FIT_BEST:  hit = !found || slack < best;
            FIT_WORST: hit = !found || slack > best;
            default:   hit = !found;
          endcase
        end
      end else begin
        hit = !found && !rd_data.free && rd_data.owner == own;
      end
    end
  end

  logic split;
  assign split = {1'b0, pick_seg.length} > {1'b0, rsize} + {{(ADDR_BITS-9){1'b0}}, split_slack};

  assign req.ready = state == S_IDLE && !rsp_valid && !boot && !cfg.valid;
  assign cfg.ready = state == S_IDLE && !rsp_valid;
  assign rsp.valid = rsp_valid;
  assign rsp.status = r_status;
  assign rsp.base_address = r_base;
  assign rsp.granted_size = r_size;
  assign rsp.free_remaining = free_units;
  assign rsp.segment_count = COUNT_BITS'(seg_total);

  // memory port control
  always_comb begin
    we = 1'b0;
    addr = '0;
    wr_data = pick_seg;
    unique case (state)
      S_IDLE: begin
        we = boot;
        wr_data = '{base: '0, length: memory_size, free: 1'b1, owner: '0};
      end
      S_SCAN:  addr = scan_i[IB-1:0];
      S_UPRD:  addr = IB'(j - 1'b1);
      S_UPWR: begin
        we = 1'b1; addr = j[IB-1:0]; wr_data = rd_data;
      end
      S_FIN_A: begin
        // write granted part at k; the free remainder goes to k+1 in S_DONE path
        we = 1'b1; addr = pick;
        wr_data = '{base: pick_seg.base, length: split ? rsize : pick_seg.length,
                    free: 1'b0, owner: own};
      end
      S_RD_NB: addr = IB'(pick + 1'b1);
      S_RD_PV: addr = IB'(pick - 1'b1);
      S_MERGE: begin
        we = 1'b1;
        if (rem_b) begin
          addr = IB'(pick - 1'b1);
          wr_data = pv_seg;
          wr_data.length = pv_seg.length + pick_seg.length
                           + (rem_a ? nb_seg.length : '0);
        end else begin
          addr = pick;
          wr_data = pick_seg;
          wr_data.free = 1'b1;
          wr_data.owner = '0;
          wr_data.length = pick_seg.length + (rem_a ? nb_seg.length : '0);
        end
      end
      S_DNRD: addr = IB'(j + drops);
      S_DNWR: begin
        we = 1'b1; addr = j[IB-1:0]; wr_data = rd_data;
      end
      S_DONE: begin
        we = act == ACT_ALLOC && split;
        addr = IB'(pick + 1'b1);
        wr_data = '{base: pick_seg.base + rsize, length: pick_seg.length - rsize,
                    free: 1'b1, owner: '0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fit_method <= FIT_FIRST;
      memory_size <= ADDR_BITS'(1024);
      split_slack <= 10'd10;
      seg_total <= CB'(1);
      free_units <= ADDR_BITS'(1024);
      rsp_valid <= 1'b0;
      boot <= 1'b1;
      cmp_v <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          boot <= 1'b0;
          if (cfg.valid && cfg.ready) begin
            unique case (cfg.index)
              REG_FIT_METHOD: fit_method <= cfg.data[1:0];
              REG_MEMORY_SIZE: begin
                memory_size <= cfg.data[ADDR_BITS-1:0];
                free_units <= cfg.data[ADDR_BITS-1:0];
                seg_total <= CB'(1);
                boot <= 1'b1;
              end
              REG_SPLIT_SLACK: split_slack <= cfg.data[9:0];
              default: ;
            endcase
          end else if (req.valid && req.ready) begin
            act <= req.action;
            own <= req.owner;
            rsize <= req.request_size;
            found <= 1'b0;
            scan_i <= '0;
            cmp_v <= 1'b0;
            if (req.action == ACT_ALLOC && req.request_size > free_units) begin
              r_status <= ST_NO_SPACE; r_base <= '0; r_size <= '0;
              rsp_valid <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // read issued at scan_i; data for cmp_i arrives now
          cmp_v <= scan_i < seg_total;
          cmp_i <= scan_i;
          scan_i <= scan_i + 1'b1;
          if (hit) begin
            found <= 1'b1;
            pick <= cmp_i[IB-1:0];
            pick_seg <= rd_data;
            best <= slack;
          end
          if ((cmp_v && !(scan_i < seg_total)) || (!cmp_v && scan_i != 0)) begin
            state <= S_DECIDE;
            cmp_v <= 1'b0;
          end
        end
        S_DECIDE: begin
          if (!found) begin
            r_status <= act == ACT_ALLOC ? ST_NO_SPACE : ST_NO_OWNER;
            r_base <= '0; r_size <= '0;
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end else if (act == ACT_ALLOC) begin
            if (split && seg_total >= CB'(SEGMENTS)) begin
              r_status <= ST_FULL; r_base <= '0; r_size <= '0;
              rsp_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              j <= seg_total;
              state <= (split && seg_total > CB'(pick) + 1'b1) ? S_UPRD : S_FIN_A;
            end
          end else begin
            rem_a <= 1'b0; rem_b <= 1'b0;
            state <= (CB'(pick) + 1'b1 < seg_total) ? S_RD_NB : S_RD_PV;
          end
        end
        S_UPRD: state <= S_UPWR;
        S_UPWR: begin
          j <= j - 1'b1;
          state <= (j - 1'b1 > CB'(pick) + 1'b1) ? S_UPRD : S_FIN_A;
        end
        S_FIN_A: begin
          r_status <= ST_OK;
          r_base <= pick_seg.base;
          r_size <= split ? rsize : pick_seg.length;
          free_units <= free_units - (split ? rsize : pick_seg.length);
          if (split) seg_total <= seg_total + 1'b1;
          state <= S_DONE;
        end
        S_RD_NB: state <= S_RD_PV;
        S_RD_PV: begin
          // rd_data now holds k+1 if it was read last cycle
          if (CB'(pick) + 1'b1 < seg_total) begin
            nb_seg <= rd_data;
            rem_a <= rd_data.free;
          end
          state <= S_MERGE;
          cmp_v <= pick != '0;
        end
        S_MERGE: begin
          // pv entry read result is only valid when cmp_v marked a read of k-1
          pv_seg <= rd_data;
          if (cmp_v) begin
            cmp_v <= 1'b0;
            rem_b <= rd_data.free;
          end else begin
            r_status <= ST_OK;
            r_base <= pick_seg.base;
            r_size <= pick_seg.length;
            free_units <= free_units + pick_seg.length;
            drops <= 2'(rem_a) + 2'(rem_b);
            j <= rem_b ? CB'(pick) : CB'(pick) + 1'b1;
            state <= (rem_a || rem_b) ? S_DNRD : S_DONE;
          end
        end
        S_DNRD: begin
          if (j + drops < seg_total) state <= S_DNWR;
          else begin
            seg_total <= seg_total - drops;
            state <= S_DONE;
          end
        end
        S_DNWR: begin
          j <= j + 1'b1;
          state <= S_DNRD;
        end
        S_DONE: begin
          rsp_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the S_MERGE write also happens on the cycle that only latches k-1
  // (handled: the write repeats with final values when S_MERGE runs again)

  assert property (@(posedge clk) disable iff (rst) rsp_valid && !rsp.ready |=> rsp_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
    seg_total != '0 && seg_total <= CB'(SEGMENTS))
    else $error("segment count out of range");
  assert property (@(posedge clk) disable iff (rst) state != S_IDLE |-> !req.ready)
    else $error("request taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !cfg.ready || rsp_valid)
    else $error("config open during item");

endmodule

/* bench/vpa_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_checker: result predictor and scoreboard of the partition allocator
// Watches request, result and configuration beats, keeps its own segment
// table, predicts each result and compares it field by field in order.
// ----------------------------------------------------------------------------
module vpa_checker
  import vpa_pkg::*;
#(
  parameter int SEGMENTS = 128
) (
  input  logic        clk,
  input  logic        rst,
  vpa_req_if.monitor  req_mon,
  vpa_rsp_if.monitor  rsp_mon,
  vpa_cfg_if.monitor  cfg_mon,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] base;
    logic [19:0] size;
    logic [19:0] free_left;
    logic [7:0]  count;
  } alloc_result_t;

  logic [19:0] tbl_base [SEGMENTS];
  logic [19:0] tbl_len  [SEGMENTS];
  logic        tbl_free [SEGMENTS];
  logic [15:0] tbl_own  [SEGMENTS];
  int          seg_used;
  logic [19:0] units_free;
  logic [1:0]  policy;
  logic [19:0] mem_units;
  logic [9:0]  slack_limit;

  alloc_result_t awaited_q[$];

  assign pending = awaited_q.size();

  task automatic report(input string what, input logic [19:0] got, input logic [19:0] want);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic void rebuild_table();
    tbl_base[0] = '0;
    tbl_len[0]  = mem_units;
    tbl_free[0] = 1'b1;
    tbl_own[0]  = '0;
    seg_used    = 1;
    units_free  = mem_units;
  endfunction

  function automatic void remove_entry(int k);
    for (int j = k; j + 1 < seg_used; j++) begin
      tbl_base[j] = tbl_base[j+1];
      tbl_len[j]  = tbl_len[j+1];
      tbl_free[j] = tbl_free[j+1];
      tbl_own[j]  = tbl_own[j+1];
    end
    seg_used--;
  endfunction

  function automatic int choose_segment(logic [19:0] want);
    int          pick;
    logic [19:0] best;
    logic [19:0] gap;
    pick = -1;
    best = '0;
    for (int i = 0; i < seg_used; i++) begin
      if (!tbl_free[i] || tbl_len[i] < want) continue;
      gap = tbl_len[i] - want;
      if (policy == FIT_BEST) begin
        if (pick < 0 || gap < best) begin pick = i; best = gap; end
      end else if (policy == FIT_WORST) begin
        if (pick < 0 || gap > best) begin pick = i; best = gap; end
      end else begin
        return i;
      end
    end
    return pick;
  endfunction

  function automatic alloc_result_t serve_request(logic act, logic [15:0] who,
                                                  logic [19:0] want);
    alloc_result_t r;
    int            k;
    bit            cut;
    r = '0;
    if (act == ACT_ALLOC) begin
      k = (want > units_free) ? -1 : choose_segment(want);
      if (k < 0) begin
        r.status = ST_NO_SPACE;
      end else begin
        cut = {1'b0, tbl_len[k]} > {1'b0, want} + slack_limit;
        if (cut && seg_used >= SEGMENTS) begin
          r.status = ST_FULL;
        end else begin
          if (cut) begin
            for (int j = seg_used; j > k + 1; j--) begin
              tbl_base[j] = tbl_base[j-1];
              tbl_len[j]  = tbl_len[j-1];
              tbl_free[j] = tbl_free[j-1];
              tbl_own[j]  = tbl_own[j-1];
            end
            tbl_base[k+1] = tbl_base[k] + want;
            tbl_len[k+1]  = tbl_len[k] - want;
            tbl_free[k+1] = 1'b1;
            tbl_own[k+1]  = '0;
            tbl_len[k]    = want;
            seg_used++;
          end
          tbl_free[k] = 1'b0;
          tbl_own[k]  = who;
          r.base      = tbl_base[k];
          r.size      = tbl_len[k];
          units_free  = units_free - tbl_len[k];
        end
      end
    end else begin
      k = -1;
      for (int i = 0; i < seg_used; i++)
        if (!tbl_free[i] && tbl_own[i] == who) begin k = i; break; end
      if (k < 0) begin
        r.status = ST_NO_OWNER;
      end else begin
        r.base      = tbl_base[k];
        r.size      = tbl_len[k];
        tbl_free[k] = 1'b1;
        tbl_own[k]  = '0;
        units_free  = units_free + tbl_len[k];
        if (k + 1 < seg_used && tbl_free[k+1]) begin
          tbl_len[k] = tbl_len[k] + tbl_len[k+1];
          remove_entry(k + 1);
        end
        if (k > 0 && tbl_free[k-1]) begin
          tbl_len[k-1] = tbl_len[k-1] + tbl_len[k];
          remove_entry(k);
        end
      end
    end
    r.free_left = units_free;
    r.count     = 8'(seg_used);
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t w;
    if (rst) begin
      policy      = FIT_FIRST;
      slack_limit = 10'd10;
      mem_units   = 20'd1024;
      rebuild_table();
      fail_count  = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_FIT_METHOD:  policy = cfg_mon.data[1:0];
          REG_MEMORY_SIZE: begin mem_units = cfg_mon.data; rebuild_table(); end
          REG_SPLIT_SLACK: slack_limit = cfg_mon.data[9:0];
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready)
        awaited_q.push_back(serve_request(req_mon.action, req_mon.owner,
                                          req_mon.request_size));
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited_q.size() == 0) begin
          report("unexpected result", '0, '0);
        end else begin
          w = awaited_q.pop_front();
          if (rsp_mon.status !== w.status) report("status", rsp_mon.status, w.status);
          if (rsp_mon.base_address !== w.base) report("base", rsp_mon.base_address, w.base);
          if (rsp_mon.granted_size !== w.size) report("size", rsp_mon.granted_size, w.size);
          if (rsp_mon.free_remaining !== w.free_left)
            report("free", rsp_mon.free_remaining, w.free_left);
          if (rsp_mon.segment_count !== w.count)
            report("count", rsp_mon.segment_count, w.count);
        end
      end
    end
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the partition allocator
// Drives directed and random allocate/release beats over several register
// settings and idling phases; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
  import vpa_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vpa_req_if req_ch ();
  vpa_rsp_if rsp_ch ();
  vpa_cfg_if cfg_ch ();

  int fail_count;
  int pending;
  int send_idle_pct;   // chance in a hundred that the sender skips a cycle
  int recv_stall_pct;  // chance in a hundred that the receiver stalls
  int hold_off_cycles; // long receiver hold-off, counted in its own process
  int hold_off_asks;   // bumped by the stimulus to start a hold-off
  int hold_off_seen;
  int owner_pool;      // owners drawn from a small range so releases hit

  variable_partition_allocator_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source),
    .cfg (cfg_ch.sink)
  );

  vpa_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req_mon    (req_ch.monitor),
    .rsp_mon    (rsp_ch.monitor),
    .cfg_mon    (cfg_ch.monitor),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: stall at random, or hold off entirely while a long stall runs.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready    <= 1'b0;
      hold_off_cycles <= 0;
      hold_off_seen   <= 0;
    end else if (hold_off_seen != hold_off_asks) begin
      hold_off_seen   <= hold_off_asks;
      hold_off_cycles <= 3000;
      rsp_ch.ready    <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      rsp_ch.ready    <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Send one request beat: idle at random first, then hold until accepted.
  // Valid stays up after the beat; drain drops it.
  task automatic send_item(input logic act, input logic [15:0] who,
                           input logic [19:0] want);
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.action       <= act;
    req_ch.owner        <= who;
    req_ch.request_size <= want;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly small requests; a few huge ones to hit the no-space paths.
  function automatic logic [19:0] pick_size(int mem);
    int r;
    r = $urandom_range(99);
    if (r < 5) return 20'($urandom);
    if (r < 10) return 20'd0;
    return 20'($urandom_range((mem / 16) + 1));
  endfunction

  task automatic random_burst(input int count, input int mem);
    logic [15:0] who;
    for (int n = 0; n < count; n++) begin
      who = (owner_pool == 0) ? 16'($urandom) : 16'($urandom_range(owner_pool));
      if ($urandom_range(99) < 55) send_item(ACT_ALLOC, who, pick_size(mem));
      else send_item(ACT_RELEASE, who, 20'($urandom));
    end
  endtask

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.action = ACT_ALLOC;
    req_ch.owner = '0;
    req_ch.request_size = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_FIT_METHOD;
    cfg_ch.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_asks = 0;
    owner_pool = 15;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, extremes of the fields, every case.
    send_item(ACT_RELEASE, 16'hFFFF, 20'hFFFFF);   // owner not found
    send_item(ACT_ALLOC, 16'h0000, 20'hFFFFF);     // larger than free space
    send_item(ACT_ALLOC, 16'h0001, 20'd0);         // zero size, split
    send_item(ACT_ALLOC, 16'hFFFF, 20'd100);
    send_item(ACT_ALLOC, 16'h0001, 20'd50);        // owner holding two
    send_item(ACT_ALLOC, 16'h0002, 20'd200);
    send_item(ACT_RELEASE, 16'hFFFF, 20'd0);       // hole between held ones
    send_item(ACT_RELEASE, 16'h0001, 20'd0);       // lowest index of owner 1
    send_item(ACT_RELEASE, 16'h0001, 20'd0);
    send_item(ACT_ALLOC, 16'h0003, 20'd665);       // within slack, whole segment kept
    send_item(ACT_ALLOC, 16'h0004, 20'd660);       // more than free space
    send_item(ACT_RELEASE, 16'h0002, 20'd0);       // merge with the free hole below
    write_reg(REG_FIT_METHOD, 20'(FIT_BEST));
    send_item(ACT_ALLOC, 16'h0005, 20'd30);
    write_reg(REG_FIT_METHOD, 20'(FIT_WORST));
    send_item(ACT_ALLOC, 16'h0006, 20'd30);
    write_reg(REG_FIT_METHOD, 20'd3);              // unused code acts as first fit
    send_item(ACT_ALLOC, 16'h0007, 20'd1);
    write_reg(REG_SPLIT_SLACK, 20'd1023);
    send_item(ACT_ALLOC, 16'h0008, 20'd1);
    write_reg(REG_MEMORY_SIZE, 20'hFFFFF);
    send_item(ACT_ALLOC, 16'h0009, 20'hFFFFF);
    send_item(ACT_RELEASE, 16'h0009, 20'd0);
    write_reg(REG_MEMORY_SIZE, 20'd1);
    send_item(ACT_ALLOC, 16'h000A, 20'd1);
    write_reg(2'd3, 20'd77);                       // index past the list: ignored

    // Fill the table to the full limit: many tiny grants with zero slack.
    write_reg(REG_MEMORY_SIZE, 20'd4000);
    write_reg(REG_SPLIT_SLACK, 20'd0);
    write_reg(REG_FIT_METHOD, 20'(FIT_FIRST));
    owner_pool = 0;
    for (int n = 0; n < 135; n++) send_item(ACT_ALLOC, 16'($urandom), 20'($urandom_range(1, 8)));

    // Random phases across settings and idling mixes.
    for (int ph = 0; ph < 8; ph++) begin
      int mem;
      mem = (ph == 7) ? 1048575 : (ph % 2 == 0 ? 1024 : $urandom_range(64, 8192));
      write_reg(REG_FIT_METHOD, 20'($urandom_range(3)));
      write_reg(REG_SPLIT_SLACK, (ph == 3) ? 20'd1023 : 20'($urandom_range(20)));
      write_reg(REG_MEMORY_SIZE, 20'(mem));
      owner_pool = (ph == 5) ? 0 : 31;
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if (ph == 2) hold_off_asks = hold_off_asks + 1; // receiver blocks; input backs up
      random_burst(75, mem);
      if (ph == 4) drain();                      // sender waits for all results
      random_burst(70, mem);
    end

    drain();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/vpa_pkg.sv
hdl/vpa_if.sv
hdl/variable_partition_allocator_top.sv
bench/vpa_checker.sv
bench/tb_top.sv
